// ===== design/mnsp_pkg.sv =====
// Package for the note string parser: beat types, result kinds and the
// command record that passes from the front end to the back end.
// Depends on nothing; every other file of the block refers to it.
package mnsp_pkg;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_OCT  = 6'b000010,
    PH_NOTE = 6'b000100,
    PH_ACC  = 6'b001000,
    PH_DUR  = 6'b010000,
    PH_EFF  = 6'b100000
  } phase_e;

  localparam logic [3:0] NoteC     = 4'd1;
  localparam logic [3:0] NoteD     = 4'd3;
  localparam logic [3:0] NoteE     = 4'd5;
  localparam logic [3:0] NoteF     = 4'd6;
  localparam logic [3:0] NoteG     = 4'd8;
  localparam logic [3:0] NoteA     = 4'd10;
  localparam logic [3:0] NoteB     = 4'd12;
  localparam logic [3:0] PauseCode = 4'd13;

  localparam logic [7:0] PausePitch     = 8'd144;
  localparam logic [7:0] StepsPerOctave = 8'd24;

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    logic       last;
  } out_t;

  typedef struct packed {
    logic       has_note;
    logic [7:0] params;
    logic [7:0] pitch;
    kind_e      status;
  } cmd_t;

endpackage

// ===== design/music_note_string_parser_top.sv =====
// Top level of the note string parser: front end, command queue, back end.
// Depends on mnsp_pkg, mnsp_front, mnsp_cmd_fifo and mnsp_back.
//
// Usage: characters of a note string enter on in_i as a queue push; a beat
// is taken when push_i is high and full_o is low. Set start_req on the
// first character of a string. Each note gives two data beats (params,
// then pitch); a quote in the octave position gives an end beat and any
// bad character an error beat, after which characters are ignored until
// the next start_req. The last beat caused by a character has last set.
// Results are read as a queue pop: out_o is valid while empty_o is low and
// is taken when pop_i is high.
// An input beat's first result passes the command queue and the output register on its way to out_o.
// The parser takes one character a cycle while full_o is low; the output side
// delivers one beat a cycle while the receiver pops every beat, set by the
// single output register, and a character gives one to three beats.
// A two-entry command queue decouples the sides: when the receiver stalls,
// the queue fills and full_o rises; nothing is dropped.
// Reset leaves the parser idle, the queue empty and empty_o high.
module music_note_string_parser_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  mnsp_pkg::in_t  in_i,
  output logic           empty_o,
  input  logic           pop_i,
  output mnsp_pkg::out_t out_o
);

  logic           accept;
  logic           cmd_valid, cmd_pop, fifo_empty;
  mnsp_pkg::cmd_t cmd, head;
  logic [1:0]     fifo_count;

  assign accept = push_i && !full_o;

  mnsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_i       (in_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd)
  );

  mnsp_cmd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (cmd_valid),
    .wr_data_i(cmd),
    .full_o   (full_o),
    .rd_i     (cmd_pop),
    .empty_o  (fifo_empty),
    .rd_data_o(head),
    .count_o  (fifo_count)
  );

  mnsp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!fifo_empty),
    .cmd_i      (head),
    .cmd_pop_o  (cmd_pop),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_o      (out_o)
  );

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count != 2'd3)
    else $error("command queue count out of range");

  a_status_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && out_o.kind != mnsp_pkg::KIND_DATA) |->
      (out_o.out_byte == 8'd0 && out_o.last))
    else $error("status beat must be zero and last");

  a_pop_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !fifo_empty)
    else $error("back end released an empty queue");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (out_o.kind == mnsp_pkg::KIND_DATA || out_o.kind == mnsp_pkg::KIND_END ||
                  out_o.kind == mnsp_pkg::KIND_ERR))
    else $error("illegal result kind");

endmodule

// ===== design/mnsp_front.sv =====
// Front end of the note string parser: takes one character a cycle while
// accept_i is high, walks the note grammar and emits one command per
// character that causes results. Depends on mnsp_pkg.
module mnsp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  mnsp_pkg::in_t  in_i,
  output logic           cmd_valid_o,
  output mnsp_pkg::cmd_t cmd_o
);

  mnsp_pkg::phase_e phase_q, phase_d, ph0;
  logic [2:0]       oct_q, oct_d;
  logic [3:0]       note_q, note_d;
  logic [2:0]       dur_q, dur_d;

  logic [7:0]       c;
  logic [3:0]       code;
  logic [1:0]       eff;
  logic             run_oct, run_dur, note_emit;
  mnsp_pkg::kind_e  status;
  logic [7:0]       oct_off, pitch;

  function automatic logic [3:0] letter_code(input logic [7:0] ch);
    logic [3:0] r;
    unique case (ch)
      "C", "c": r = mnsp_pkg::NoteC;
      "D", "d": r = mnsp_pkg::NoteD;
      "E", "e": r = mnsp_pkg::NoteE;
      "F", "f": r = mnsp_pkg::NoteF;
      "G", "g": r = mnsp_pkg::NoteG;
      "A", "a": r = mnsp_pkg::NoteA;
      "B", "b": r = mnsp_pkg::NoteB;
      "P", "p": r = mnsp_pkg::PauseCode;
      default:  r = 4'd0;
    endcase
    return r;
  endfunction

  assign c    = in_i.ch;
  assign code = letter_code(c);
  assign ph0  = in_i.start_req ? mnsp_pkg::PH_OCT : phase_q;

  always_comb begin
    unique case (c)
      "+":     eff = 2'd1;
      "-":     eff = 2'd2;
      "=":     eff = 2'd3;
      default: eff = 2'd0;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    oct_d     = oct_q;
    note_d    = note_q;
    dur_d     = dur_q;
    run_oct   = 1'b0;
    run_dur   = 1'b0;
    note_emit = 1'b0;
    status    = mnsp_pkg::KIND_DATA;
    unique case (ph0)
      mnsp_pkg::PH_OCT: run_oct = 1'b1;
      mnsp_pkg::PH_NOTE: begin
        if (code == 4'd0) begin
          status  = mnsp_pkg::KIND_ERR;
          phase_d = mnsp_pkg::PH_IDLE;
        end else begin
          note_d = code;
          if (code == mnsp_pkg::NoteD || code == mnsp_pkg::NoteA ||
              code == mnsp_pkg::PauseCode) begin
            phase_d = mnsp_pkg::PH_DUR;
          end else begin
            phase_d = mnsp_pkg::PH_ACC;
          end
        end
      end
      mnsp_pkg::PH_ACC: begin
        if (c == "#" && (note_q == mnsp_pkg::NoteC || note_q == mnsp_pkg::NoteF ||
                         note_q == mnsp_pkg::NoteG)) begin
          note_d  = note_q + 4'd1;
          phase_d = mnsp_pkg::PH_DUR;
        end else if ((c == "b" || c == "B") &&
                     (note_q == mnsp_pkg::NoteE || note_q == mnsp_pkg::NoteB)) begin
          note_d  = note_q - 4'd1;
          phase_d = mnsp_pkg::PH_DUR;
        end else begin
          run_dur = 1'b1;
        end
      end
      mnsp_pkg::PH_DUR: run_dur = 1'b1;
      mnsp_pkg::PH_EFF: begin
        note_emit = 1'b1;
        if (eff == 2'd0) begin
          run_oct = 1'b1;
        end else begin
          phase_d = mnsp_pkg::PH_OCT;
        end
      end
      default: phase_d = mnsp_pkg::PH_IDLE;
    endcase

    if (run_oct) begin
      if (c >= "2" && c <= "7") begin
        oct_d   = c[2:0];
        phase_d = mnsp_pkg::PH_NOTE;
      end else if (c == 8'h22 || c == 8'h27) begin
        status  = mnsp_pkg::KIND_END;
        phase_d = mnsp_pkg::PH_IDLE;
      end else begin
        status  = mnsp_pkg::KIND_ERR;
        phase_d = mnsp_pkg::PH_IDLE;
      end
    end

    if (run_dur) begin
      if (c >= "1" && c <= "8") begin
        dur_d   = c[2:0] - 3'd1;
        phase_d = mnsp_pkg::PH_EFF;
      end else begin
        status  = mnsp_pkg::KIND_ERR;
        phase_d = mnsp_pkg::PH_IDLE;
      end
    end
  end

  assign oct_off = 8'({5'd0, oct_q} - 8'd2) * mnsp_pkg::StepsPerOctave;
  assign pitch   = (note_q == mnsp_pkg::PauseCode) ? mnsp_pkg::PausePitch :
                   8'(oct_off + {3'd0, note_q - 4'd1, 1'b0});

  assign cmd_valid_o     = accept_i && (note_emit || status != mnsp_pkg::KIND_DATA);
  assign cmd_o.has_note  = note_emit;
  assign cmd_o.params    = {eff, 3'd0, dur_q};
  assign cmd_o.pitch     = pitch;
  assign cmd_o.status    = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mnsp_pkg::PH_IDLE;
      oct_q   <= 3'd0;
      note_q  <= 4'd0;
      dur_q   <= 3'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      oct_q   <= oct_d;
      note_q  <= note_d;
      dur_q   <= dur_d;
    end
  end

endmodule

// ===== design/mnsp_cmd_fifo.sv =====
// Two-entry command queue between the parser front end and the beat
// generator, so that each side can stall on its own. Depends on mnsp_pkg.
module mnsp_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  mnsp_pkg::cmd_t wr_data_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           empty_o,
  output mnsp_pkg::cmd_t rd_data_o,
  output logic [1:0]     count_o
);

  mnsp_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign count_o   = count_q;

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_i && !full_o) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_i && !empty_o) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'((wr_i && !full_o) ? 1 : 0) - 2'((rd_i && !empty_o) ? 1 : 0);
    end
  end

endmodule

// ===== design/mnsp_back.sv =====
// Back end of the note string parser: expands each queued command into one
// to three result beats and holds the oldest one in an output register.
// Depends on mnsp_pkg.
module mnsp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  mnsp_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           empty_o,
  input  logic           pop_i,
  output mnsp_pkg::out_t out_o
);

  logic [1:0]     beat_q, beat_d, idx;
  logic           out_valid_q;
  mnsp_pkg::out_t out_q, beat;
  logic           load;

  assign idx = cmd_i.has_note ? beat_q : 2'd2;

  always_comb begin
    beat.out_byte = 8'd0;
    beat.kind     = cmd_i.status;
    beat.last     = 1'b1;
    unique case (idx)
      2'd0: begin
        beat.out_byte = cmd_i.params;
        beat.kind     = mnsp_pkg::KIND_DATA;
        beat.last     = 1'b0;
      end
      2'd1: begin
        beat.out_byte = cmd_i.pitch;
        beat.kind     = mnsp_pkg::KIND_DATA;
        beat.last     = (cmd_i.status == mnsp_pkg::KIND_DATA);
      end
      default: ;
    endcase
  end

  assign load      = cmd_valid_i && (!out_valid_q || pop_i);
  assign cmd_pop_o = load && beat.last;
  assign beat_d    = beat.last ? 2'd0 : idx + 2'd1;
  assign empty_o   = !out_valid_q;
  assign out_o     = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        beat_q      <= beat_d;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
